>>> rtl/udm_pkg.sv
// Shared types, codes and the CRC-8 byte step of the register datagram master.
package udm_pkg;

  // Input item kinds, carried on in_tuser.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_RX    = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  // Result kinds, carried on out_tuser.
  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Completion status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_REPLY = 2'd1;
  localparam logic [1:0] ST_FORMAT   = 2'd2;
  localparam logic [1:0] ST_BAD_CRC  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SYNC    = 2'd0;
  localparam logic [1:0] CFG_SLAVE   = 2'd1;
  localparam logic [1:0] CFG_MASTER  = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT = 2'd3;

  localparam logic [7:0]  SYNC_RESET    = 8'h05;
  localparam logic [7:0]  SLAVE_RESET   = 8'h00;
  localparam logic [7:0]  MASTER_RESET  = 8'hFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  localparam logic [7:0]  CRC_POLY   = 8'h07;
  localparam logic [7:0]  WRITE_FLAG = 8'h80;
  localparam logic [31:0] ERR_DATA   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0]  sync_code;
    logic [7:0]  slave_address;
    logic [7:0]  master_addr;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  reg_address;
    logic [31:0] write_value;
    logic [7:0]  rx_byte;
  } item_t;

  // Everything one input item produces: up to eight transmit bytes or one completion.
  typedef struct packed {
    logic            valid;
    logic            kind;
    logic [2:0]      last_idx;
    logic [1:0]      status;
    logic [31:0]     read_data;
    logic [7:0][7:0] bytes;
  } result_t;

  // One byte through the CRC-8 (poly 0x07), data bits taken LSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc_in;
    for (int b = 0; b < 8; b++) begin
      fb = c[7] ^ data[b];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

endpackage

>>> rtl/udm_engine.sv
// Datagram engine: frame building, reply receiver state and the result of one item.
module udm_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  udm_pkg::cfg_t    cfg,
  input  udm_pkg::item_t   item,
  input  logic             take,
  output udm_pkg::result_t res
);

  logic        armed_r,   armed_nxt;
  logic [6:0]  exp_reg_r, exp_reg_nxt;
  logic [2:0]  cnt_r,     cnt_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [7:0]  crc_r,     crc_nxt;
  logic [7:0]  reply_r [7];
  logic        store;

  always_comb begin
    logic [7:0]  c;
    logic [15:0] el_inc;
    logic [7:0]  b2;
    armed_nxt   = armed_r;
    exp_reg_nxt = exp_reg_r;
    cnt_nxt     = cnt_r;
    elapsed_nxt = elapsed_r;
    crc_nxt     = crc_r;
    store       = 1'b0;
    res         = '0;
    c           = 8'h00;
    el_inc      = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
    case (item.cmd)
      udm_pkg::CMD_READ: begin
        b2 = {1'b0, item.reg_address};
        c  = udm_pkg::crc8_byte(8'h00, cfg.sync_code);
        c  = udm_pkg::crc8_byte(c, cfg.slave_address);
        c  = udm_pkg::crc8_byte(c, b2);
        res.valid    = 1'b1;
        res.kind     = udm_pkg::KIND_TX;
        res.last_idx = 3'd3;
        res.bytes[0] = cfg.sync_code;
        res.bytes[1] = cfg.slave_address;
        res.bytes[2] = b2;
        res.bytes[3] = c;
        armed_nxt    = 1'b1;
        exp_reg_nxt  = item.reg_address;
        cnt_nxt      = 3'd0;
        elapsed_nxt  = 16'd0;
      end
      udm_pkg::CMD_WRITE: begin
        b2 = {1'b0, item.reg_address} | udm_pkg::WRITE_FLAG;
        c  = udm_pkg::crc8_byte(8'h00, cfg.sync_code);
        c  = udm_pkg::crc8_byte(c, cfg.slave_address);
        c  = udm_pkg::crc8_byte(c, b2);
        c  = udm_pkg::crc8_byte(c, item.write_value[31:24]);
        c  = udm_pkg::crc8_byte(c, item.write_value[23:16]);
        c  = udm_pkg::crc8_byte(c, item.write_value[15:8]);
        c  = udm_pkg::crc8_byte(c, item.write_value[7:0]);
        res.valid    = 1'b1;
        res.kind     = udm_pkg::KIND_TX;
        res.last_idx = 3'd7;
        res.bytes[0] = cfg.sync_code;
        res.bytes[1] = cfg.slave_address;
        res.bytes[2] = b2;
        res.bytes[3] = item.write_value[31:24];
        res.bytes[4] = item.write_value[23:16];
        res.bytes[5] = item.write_value[15:8];
        res.bytes[6] = item.write_value[7:0];
        res.bytes[7] = c;
      end
      udm_pkg::CMD_RX: begin
        b2 = 8'h00;
        if (armed_r && !(cnt_r == 3'd0 && item.rx_byte != cfg.sync_code)) begin
          if (cnt_r == 3'd7) begin
            // Eighth byte closes the reply; it is the CRC over the seven before it.
            armed_nxt     = 1'b0;
            cnt_nxt       = 3'd0;
            res.valid     = 1'b1;
            res.kind      = udm_pkg::KIND_DONE;
            res.read_data = udm_pkg::ERR_DATA;
            if (reply_r[0] != cfg.sync_code || reply_r[1] != cfg.master_addr ||
                reply_r[2] != {1'b0, exp_reg_r}) begin
              res.status = udm_pkg::ST_FORMAT;
            end else if (crc_r != item.rx_byte) begin
              res.status = udm_pkg::ST_BAD_CRC;
            end else begin
              res.status    = udm_pkg::ST_OK;
              res.read_data = {reply_r[3], reply_r[4], reply_r[5], reply_r[6]};
            end
          end else begin
            store   = 1'b1;
            cnt_nxt = cnt_r + 3'd1;
            crc_nxt = udm_pkg::crc8_byte((cnt_r == 3'd0) ? 8'h00 : crc_r, item.rx_byte);
          end
        end
      end
      default: begin
        b2 = 8'h00;
        if (armed_r) begin
          elapsed_nxt = el_inc;
          if (el_inc >= cfg.timeout_ticks) begin
            armed_nxt     = 1'b0;
            cnt_nxt       = 3'd0;
            res.valid     = 1'b1;
            res.kind      = udm_pkg::KIND_DONE;
            res.status    = udm_pkg::ST_NO_REPLY;
            res.read_data = udm_pkg::ERR_DATA;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r   <= 1'b0;
      exp_reg_r <= '0;
      cnt_r     <= '0;
      elapsed_r <= '0;
    end else if (take) begin
      armed_r   <= armed_nxt;
      exp_reg_r <= exp_reg_nxt;
      cnt_r     <= cnt_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      crc_r <= crc_nxt;
      if (store) begin
        reply_r[cnt_r] <= item.rx_byte;
      end
    end
  end

endmodule

>>> rtl/uart_register_datagram_master_unit.sv
// Top level of the UART register datagram master: ports, registers, input stage and output buffer.
//
//  Channel  Direction  Handshake           Payload
//  in_      slave      tvalid / tready     tuser: cmd; tdata: reg_address, write_value, rx_byte
//  out_     master     tvalid / tready     tuser: kind; tlast: last; tdata: tx_byte, status,
//                                          read_data
//  cfg_     write      cfg_we              cfg_index selects the register, cfg_wdata the value
//
// Every request passes through an input register, is evaluated combinationally by the datagram
// engine, and its results are parked in an eight-byte output buffer that drains one beat per
// cycle while out_tready is high. A received byte or tick gives at most one beat; a read request
// occupies the output for four beats and a write request for eight, which bounds the sustained rate.
// A request with no result (an ignored byte or tick) never touches the buffer.
// Reset is synchronous and active low; it restores the register defaults and disarms the receiver.
// A stall on the output holds the buffer and, once the input register is full, the input.
module uart_register_datagram_master_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  input  logic [47:0] in_tdata,   // [6:0] reg_address, [38:7] write_value, [46:39] rx_byte
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tlast,
  output logic [0:0]  out_tuser,  // [0] kind
  output logic [47:0] out_tdata,  // [7:0] tx_byte, [9:8] status, [41:10] read_data
  // Configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  udm_pkg::cfg_t    cfg_r;
  udm_pkg::item_t   stage_r;
  logic             stage_v_r;
  udm_pkg::result_t buf_r;
  logic             buf_v_r;
  logic [2:0]       idx_r;
  udm_pkg::result_t res;
  logic             out_fire;
  logic             buf_free;
  logic             take;
  logic             beat_last;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_code     <= udm_pkg::SYNC_RESET;
      cfg_r.slave_address <= udm_pkg::SLAVE_RESET;
      cfg_r.master_addr   <= udm_pkg::MASTER_RESET;
      cfg_r.timeout_ticks <= udm_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        udm_pkg::CFG_SYNC:    cfg_r.sync_code     <= cfg_wdata[7:0];
        udm_pkg::CFG_SLAVE:   cfg_r.slave_address <= cfg_wdata[7:0];
        udm_pkg::CFG_MASTER:  cfg_r.master_addr   <= cfg_wdata[7:0];
        udm_pkg::CFG_TIMEOUT: cfg_r.timeout_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The buffer frees up when empty or when its final beat leaves this cycle, so a new
  // request can be evaluated right behind the previous one.
  assign beat_last = (idx_r == buf_r.last_idx);
  assign out_fire  = out_tvalid && out_tready;
  assign buf_free  = !buf_v_r || (out_fire && beat_last);
  assign take      = stage_v_r && buf_free;
  assign in_tready = !stage_v_r || take;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_tready) begin
      stage_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stage_r.cmd         <= in_tuser;
      stage_r.reg_address <= in_tdata[6:0];
      stage_r.write_value <= in_tdata[38:7];
      stage_r.rx_byte     <= in_tdata[46:39];
    end
  end

  udm_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .item  (stage_r),
    .take  (take),
    .res   (res)
  );

  // Output buffer: holds one request's results and walks through them beat by beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_v_r <= 1'b0;
      idx_r   <= '0;
    end else if (take && res.valid) begin
      buf_v_r <= 1'b1;
      idx_r   <= '0;
    end else if (out_fire && beat_last) begin
      buf_v_r <= 1'b0;
      idx_r   <= '0;
    end else if (out_fire) begin
      idx_r   <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.valid) begin
      buf_r <= res;
    end
  end

  assign out_tvalid   = buf_v_r;
  assign out_tlast    = beat_last;
  assign out_tuser[0] = buf_r.kind;
  assign out_tdata    = {6'b0, buf_r.read_data, buf_r.status, buf_r.bytes[idx_r]};

  // A completion is always a single beat.
  a_done_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] == udm_pkg::KIND_DONE |-> out_tlast)
    else $error("completion without tlast");

  // The beat index never runs past the last byte of the buffered frame.
  a_idx_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    buf_v_r |-> idx_r <= buf_r.last_idx)
    else $error("output beat index beyond frame end");

  // Transmit beats carry neither status nor read data.
  a_tx_clean : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] == udm_pkg::KIND_TX |-> out_tdata[41:8] == 34'd0)
    else $error("transmit beat with status or data");

  // A request is only taken from the input register when its results have room.
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    buf_v_r && !out_fire |=> buf_v_r && $stable(buf_r))
    else $error("output buffer changed while a beat was pending");

endmodule

>>> dv/tb_uart_register_datagram_master_unit.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the UART register datagram master unit.
module tb_uart_register_datagram_master_unit;

  // The run is short. The watchdog limit is far above the slowest legal run, which is
  // about 160 requests of up to eight beats each, every beat waiting out the receiver's
  // stalls.
  localparam int CYCLE_LIMIT   = 200000;
  // Cycles to wait after the last expected beat. This covers the input register, the
  // evaluation stage and requests that give no beat but may still be in flight.
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS   = 30;
  localparam int STALL_CYCLES  = 300;

  // One beat on the result channel, field by field.
  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [1:0]  status;
    logic [31:0] read_data;
  } beat_t;

  // Ways a generated reply datagram can be damaged before it goes back to the master.
  typedef enum {
    FAULT_NONE, FAULT_MASTER, FAULT_REG, FAULT_REG_HIGH, FAULT_CRC, FAULT_BOTH
  } reply_fault_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser   = udm_pkg::CMD_TICK;  // [1:0] cmd
  logic [47:0] in_tdata   = '0;  // [6:0] reg_address, [38:7] write_value, [46:39] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        out_tlast;
  logic [0:0]  out_tuser;        // [0] kind
  logic [47:0] out_tdata;        // [7:0] tx_byte, [9:8] status, [41:10] read_data
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = udm_pkg::CFG_SYNC;
  logic [15:0] cfg_wdata  = '0;

  // The testbench's own copy of the block's state and settings.
  udm_pkg::cfg_t   shadow_cfg;
  logic            rx_armed;
  logic [6:0]      rx_register;
  logic [3:0]      rx_count;
  logic [7:0][7:0] rx_reply;
  logic [15:0]     rx_elapsed;

  // Beats still owed by the block, oldest first.
  beat_t expected_beats[$];

  int mismatches       = 0;
  int served_items     = 0;  // requests the block acted on (ignored ones excluded)
  int cycle_count      = 0;
  int sender_gap_pct   = 0;
  int receiver_gap_pct = 0;
  int stall_left       = 0;  // long receiver hold-off, counted down by the receiver process

  uart_register_datagram_master_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  // The watchdog. Reaching the limit means the block hung or lost beats.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // The result receiver. It stalls at random at the current rate. A requested hold-off
  // overrides this and keeps tready low for a long stretch, so the output buffer fills
  // and the block must stall its input.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_gap_pct);
    end
  end

  // The beat checker. Outputs are sampled at the edge where the handshake completes,
  // before any of that edge's updates land, so the order of processes cannot matter.
  always @(posedge clk) begin : check_beat
    beat_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (expected_beats.size() == 0) begin
        $error("result with nothing expected: kind %0d tdata %h", out_tuser[0], out_tdata);
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        if (out_tuser[0] !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_tuser[0]);
          mismatches++;
        end
        if (out_tdata[7:0] !== want.tx_byte) begin
          $error("tx_byte: expected %h, got %h", want.tx_byte, out_tdata[7:0]);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_tlast);
          mismatches++;
        end
        if (out_tdata[9:8] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[9:8]);
          mismatches++;
        end
        if (out_tdata[41:10] !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_tdata[41:10]);
          mismatches++;
        end
      end
    end
  end

  // CRC-8, polynomial 0x07, initial value zero. Each byte is taken LSB first.
  function automatic logic [7:0] crc8_poly07(input logic [7:0][7:0] bytes_in, input int len);
    logic [7:0] crc;
    logic [7:0] cur;
    logic       fb;
    crc = 8'h00;
    for (int i = 0; i < len; i++) begin
      cur = bytes_in[i];
      for (int b = 0; b < 8; b++) begin
        fb  = crc[7] ^ cur[b];
        crc = {crc[6:0], 1'b0};
        if (fb) crc = crc ^ udm_pkg::CRC_POLY;
      end
    end
    return crc;
  endfunction

  // Expected behavior of the master for one accepted request. The beats it owes go
  // into the queue. used is cleared when the block simply ignores the request.
  task automatic predict_datagram(input udm_pkg::item_t it, output bit used);
    logic [7:0][7:0] frame;
    int              len;
    logic [31:0]     word;
    used  = 1'b1;
    frame = '0;
    case (it.cmd)
      udm_pkg::CMD_READ, udm_pkg::CMD_WRITE: begin
        frame[0] = shadow_cfg.sync_code;
        frame[1] = shadow_cfg.slave_address;
        if (it.cmd == udm_pkg::CMD_READ) begin
          // A read always restarts the receiver. Any pending read is dropped silently.
          frame[2]    = {1'b0, it.reg_address};
          len         = 4;
          rx_armed    = 1'b1;
          rx_register = it.reg_address;
          rx_count    = '0;
          rx_elapsed  = '0;
        end else begin
          // A write leaves the receiver as it is, even in the middle of a reply.
          frame[2] = udm_pkg::WRITE_FLAG | {1'b0, it.reg_address};
          frame[3] = it.write_value[31:24];
          frame[4] = it.write_value[23:16];
          frame[5] = it.write_value[15:8];
          frame[6] = it.write_value[7:0];
          len      = 8;
        end
        frame[len-1] = crc8_poly07(frame, len - 1);
        for (int i = 0; i < len; i++)
          expected_beats.push_back({udm_pkg::KIND_TX, frame[i], i == len - 1,
                                    udm_pkg::ST_OK, 32'h0});
      end
      udm_pkg::CMD_RX: begin
        // Bytes are ignored while idle. Until a sync byte is held, others are skipped.
        if (!rx_armed || (rx_count == 0 && it.rx_byte != shadow_cfg.sync_code)) begin
          used = 1'b0;
        end else begin
          rx_reply[rx_count[2:0]] = it.rx_byte;
          rx_count = rx_count + 4'd1;
          if (rx_count == 4'd8) begin
            rx_armed = 1'b0;
            rx_count = '0;
            // The format check comes before the CRC check.
            if (rx_reply[0] != shadow_cfg.sync_code || rx_reply[1] != shadow_cfg.master_addr ||
                rx_reply[2] != {1'b0, rx_register}) begin
              expected_beats.push_back({udm_pkg::KIND_DONE, 8'h00, 1'b1, udm_pkg::ST_FORMAT,
                                        udm_pkg::ERR_DATA});
            end else if (crc8_poly07(rx_reply, 7) != rx_reply[7]) begin
              expected_beats.push_back({udm_pkg::KIND_DONE, 8'h00, 1'b1, udm_pkg::ST_BAD_CRC,
                                        udm_pkg::ERR_DATA});
            end else begin
              word = {rx_reply[3], rx_reply[4], rx_reply[5], rx_reply[6]};
              expected_beats.push_back({udm_pkg::KIND_DONE, 8'h00, 1'b1, udm_pkg::ST_OK, word});
            end
          end
        end
      end
      default: begin
        // A tick counts toward the reply timeout. The count saturates at the top.
        if (!rx_armed) begin
          used = 1'b0;
        end else begin
          if (rx_elapsed != 16'hFFFF) rx_elapsed = rx_elapsed + 16'd1;
          if (rx_elapsed >= shadow_cfg.timeout_ticks) begin
            rx_armed = 1'b0;
            rx_count = '0;
            expected_beats.push_back({udm_pkg::KIND_DONE, 8'h00, 1'b1, udm_pkg::ST_NO_REPLY,
                                      udm_pkg::ERR_DATA});
          end
        end
      end
    endcase
  endtask

  // Offers one request and waits for the block to take it. Valid is never dropped here
  // after acceptance. The next request or settle() does that in the same time step,
  // so valid gets one update per step.
  task automatic send_request(input logic [1:0] cmd, input logic [6:0] reg_addr,
                              input logic [31:0] wval, input logic [7:0] rx);
    udm_pkg::item_t it;
    bit             used;
    it.cmd         = cmd;
    it.reg_address = reg_addr;
    it.write_value = wval;
    it.rx_byte     = rx;
    while ($urandom_range(99) < sender_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, rx, wval, reg_addr};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    predict_datagram(it, used);
    if (used) served_items++;
  endtask

  // Fields a command does not use carry random junk. The block must ignore it.
  task automatic do_read(input logic [6:0] reg_addr);
    send_request(udm_pkg::CMD_READ, reg_addr, $urandom, 8'($urandom));
  endtask

  task automatic do_write(input logic [6:0] reg_addr, input logic [31:0] value);
    send_request(udm_pkg::CMD_WRITE, reg_addr, value, 8'($urandom));
  endtask

  task automatic do_rx(input logic [7:0] rx);
    send_request(udm_pkg::CMD_RX, 7'($urandom), $urandom, rx);
  endtask

  task automatic do_tick();
    send_request(udm_pkg::CMD_TICK, 7'($urandom), $urandom, 8'($urandom));
  endtask

  // Plays the slave's answer to a read of reg_addr. lead non-sync bytes come first.
  // When the timeout leaves room, stray ticks can fall between the reply bytes.
  task automatic send_reply(input logic [6:0] reg_addr, input reply_fault_t fault,
                            input int lead);
    logic [7:0][7:0] reply;
    logic [7:0]      noise;
    logic [31:0]     word;
    word     = $urandom;
    reply[0] = shadow_cfg.sync_code;
    reply[1] = shadow_cfg.master_addr;
    reply[2] = {1'b0, reg_addr};
    reply[3] = word[31:24];
    reply[4] = word[23:16];
    reply[5] = word[15:8];
    reply[6] = word[7:0];
    if (fault == FAULT_MASTER || fault == FAULT_BOTH)
      reply[1] = reply[1] ^ (8'h01 << $urandom_range(7));
    if (fault == FAULT_REG)
      reply[2] = {1'b0, reg_addr ^ (7'h01 << $urandom_range(6))};
    if (fault == FAULT_REG_HIGH)
      reply[2][7] = 1'b1;
    reply[7] = crc8_poly07(reply, 7);
    if (fault == FAULT_CRC || fault == FAULT_BOTH)
      reply[7] = reply[7] ^ (8'h01 << $urandom_range(7));
    for (int i = 0; i < lead; i++) begin
      noise = 8'($urandom);
      if (noise == shadow_cfg.sync_code) noise = noise ^ 8'h01;
      do_rx(noise);
    end
    for (int i = 0; i < 8; i++) begin
      if (shadow_cfg.timeout_ticks > 9 && $urandom_range(9) == 0) do_tick();
      do_rx(reply[i]);
    end
  endtask

  function automatic reply_fault_t pick_fault();
    case ($urandom_range(9))
      5:       return FAULT_MASTER;
      6:       return FAULT_REG;
      7:       return FAULT_REG_HIGH;
      8:       return FAULT_CRC;
      9:       return FAULT_BOTH;
      default: return FAULT_NONE;
    endcase
  endfunction

  // Drops valid, waits for every owed beat, then lets in-flight requests that give no
  // beat run out. After this the block is idle and the registers may be written.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers on consecutive edges. The unused upper bits of the byte
  // registers carry junk that the block must mask off.
  task automatic load_settings(input logic [7:0] sync_val, input logic [7:0] slave_val,
                               input logic [7:0] master_val, input logic [15:0] timeout_val);
    cfg_we    <= 1'b1;
    cfg_index <= udm_pkg::CFG_SYNC;
    cfg_wdata <= {8'($urandom), sync_val};
    @(posedge clk);
    cfg_index <= udm_pkg::CFG_SLAVE;
    cfg_wdata <= {8'($urandom), slave_val};
    @(posedge clk);
    cfg_index <= udm_pkg::CFG_MASTER;
    cfg_wdata <= {8'($urandom), master_val};
    @(posedge clk);
    cfg_index <= udm_pkg::CFG_TIMEOUT;
    cfg_wdata <= timeout_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_cfg.sync_code     = sync_val;
    shadow_cfg.slave_address = slave_val;
    shadow_cfg.master_addr   = master_val;
    shadow_cfg.timeout_ticks = timeout_val;
  endtask

  // Mostly well-formed exchanges with random content. Replies are clean or damaged,
  // reads may time out or be restarted, and writes may cut into a pending read. The
  // rest is stray bytes and ticks.
  task automatic random_traffic(input int target);
    int         start;
    int         pick;
    logic [6:0] first_reg;
    logic [6:0] next_reg;
    start = served_items;
    while (served_items - start < target) begin
      pick      = $urandom_range(99);
      first_reg = 7'($urandom_range(127));
      next_reg  = 7'($urandom_range(127));
      if (pick < 15) begin
        do_write(first_reg, $urandom);
      end else if (pick < 65) begin
        do_read(first_reg);
        send_reply(first_reg, pick_fault(), $urandom_range(2));
      end else if (pick < 75) begin
        // The slave stays silent. A short timeout runs out. A long one is left pending.
        do_read(first_reg);
        repeat ((shadow_cfg.timeout_ticks <= 40) ? int'(shadow_cfg.timeout_ticks) : 3)
          do_tick();
      end else if (pick < 82) begin
        // A reply is cut short by a new read, which must restart the receiver.
        do_read(first_reg);
        do_rx(shadow_cfg.sync_code);
        do_rx(shadow_cfg.master_addr);
        do_read(next_reg);
        send_reply(next_reg, FAULT_NONE, 0);
      end else if (pick < 89) begin
        do_read(first_reg);
        do_write(next_reg, $urandom);
        send_reply(first_reg, pick_fault(), 0);
      end else if (pick < 95) begin
        do_rx(8'($urandom));
      end else begin
        do_tick();
      end
    end
  endtask

  // Runs with the reset settings. It covers field extremes, bytes and ticks while idle,
  // skipped leading bytes, a read that replaces a pending read, a write while a read is
  // pending, and an echoed register with the top bit set.
  task automatic test_directed_cases();
    do_write(7'h00, 32'h0000_0000);
    do_write(7'h7F, 32'hFFFF_FFFF);
    do_rx(8'hA5);
    do_tick();
    do_read(7'h7F);
    send_reply(7'h7F, FAULT_NONE, 1);
    do_read(7'h12);
    do_read(7'h00);
    do_write(7'h33, 32'h1234_5678);
    send_reply(7'h00, FAULT_REG_HIGH, 0);
  endtask

  // Lowest values everywhere. A timeout of one tick ends a read at its first tick.
  task automatic test_low_extremes();
    settle();
    load_settings(8'h00, 8'h00, 8'h00, 16'd1);
    random_traffic(PHASE_ITEMS);
  endtask

  // Highest values. With the longest timeout, stray ticks never end a read.
  task automatic test_high_extremes();
    settle();
    load_settings(8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    random_traffic(PHASE_ITEMS);
  endtask

  // Random addresses with short timeouts, so timeouts happen often. The second round
  // leaves room for stray ticks inside replies.
  task automatic test_mixed_settings();
    settle();
    load_settings(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(2, 9)));
    random_traffic(PHASE_ITEMS / 2);
    settle();
    load_settings(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(10, 40)));
    random_traffic(PHASE_ITEMS / 2);
  endtask

  // The receiver holds off for a long stretch. Meanwhile write frames keep coming, so
  // the output buffer fills and the input must stall without losing a beat.
  task automatic test_backpressure();
    settle();
    stall_left = STALL_CYCLES;
    repeat (12) do_write(7'($urandom_range(127)), $urandom);
  endtask

  initial begin
    shadow_cfg.sync_code     = udm_pkg::SYNC_RESET;
    shadow_cfg.slave_address = udm_pkg::SLAVE_RESET;
    shadow_cfg.master_addr   = udm_pkg::MASTER_RESET;
    shadow_cfg.timeout_ticks = udm_pkg::TIMEOUT_RESET;
    rx_armed    = 1'b0;
    rx_register = '0;
    rx_count    = '0;
    rx_reply    = '0;
    rx_elapsed  = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    sender_gap_pct   = 14;
    receiver_gap_pct = 56;
    test_directed_cases();
    test_low_extremes();

    sender_gap_pct   = 56;
    receiver_gap_pct = 14;
    test_high_extremes();

    sender_gap_pct   = 0;
    receiver_gap_pct = 0;
    test_mixed_settings();
    test_backpressure();

    settle();
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/udm_pkg.sv
rtl/udm_engine.sv
rtl/uart_register_datagram_master_unit.sv
dv/tb_uart_register_datagram_master_unit.sv
